// File: hw/rtl/interval_list_subtractor_unit_assert.svh
// assertion macros, clocked on i_clk, off during reset
`ifndef INTERVAL_LIST_SUBTRACTOR_UNIT_ASSERT_SVH
`define INTERVAL_LIST_SUBTRACTOR_UNIT_ASSERT_SVH

`define ILS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ILS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ils_pkg.sv
package ils_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int VALUE_BITS  = 32;
    localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CUR_W       = VALUE_BITS + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SKIP_RD,
        ST_SKIP_CHK,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_TAIL,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic start_sub;
        logic skip_adv;
        logic skip_done;
        logic walk_step;
        logic tail;
        logic fin;
    } t_dp_cmd;

    typedef struct packed {
        logic k_lt_cnt;
        logic skip_cond;
        logic walk_cond;
    } t_dp_sts;

endpackage

// File: hw/rtl/ils_ctrl.sv
module ils_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_func,
    input  ils_pkg::t_dp_sts  i_sts,
    output ils_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy
);

    ils_pkg::t_state r_state;
    ils_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ils_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            ils_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    if (i_func) begin
                        o_cmd.start_sub = 1'b1;
                        n_state         = ils_pkg::ST_SKIP_RD;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            ils_pkg::ST_SKIP_RD: begin
                if (i_sts.k_lt_cnt) begin
                    n_state = ils_pkg::ST_SKIP_CHK;
                end else begin
                    o_cmd.skip_done = 1'b1;
                    n_state         = ils_pkg::ST_TAIL;
                end
            end
            ils_pkg::ST_SKIP_CHK: begin
                if (i_sts.skip_cond) begin
                    o_cmd.skip_adv = 1'b1;
                    n_state        = ils_pkg::ST_SKIP_RD;
                end else begin
                    o_cmd.skip_done = 1'b1;
                    n_state         = ils_pkg::ST_WALK_CHK;
                end
            end
            ils_pkg::ST_WALK_RD: begin
                n_state = i_sts.k_lt_cnt ? ils_pkg::ST_WALK_CHK : ils_pkg::ST_TAIL;
            end
            ils_pkg::ST_WALK_CHK: begin
                if (i_sts.walk_cond) begin
                    o_cmd.walk_step = 1'b1;
                    n_state         = ils_pkg::ST_WALK_RD;
                end else begin
                    n_state = ils_pkg::ST_TAIL;
                end
            end
            ils_pkg::ST_TAIL: begin
                o_cmd.tail = 1'b1;
                n_state    = ils_pkg::ST_FIN;
            end
            ils_pkg::ST_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = ils_pkg::ST_IDLE;
            end
            default: begin
                n_state = ils_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/ils_dp.sv
`include "interval_list_subtractor_unit_assert.svh"

module ils_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ils_pkg::t_dp_cmd                i_cmd,
    input  logic [ils_pkg::VALUE_BITS-1:0]  i_lo,
    input  logic [ils_pkg::VALUE_BITS-1:0]  i_hi,
    input  logic                            i_last_of_list,
    output ils_pkg::t_dp_sts                o_sts,
    output logic                            o_strobe,
    output logic [ils_pkg::VALUE_BITS-1:0]  o_piece_lo,
    output logic [ils_pkg::VALUE_BITS-1:0]  o_piece_hi,
    output logic                            o_piece_valid,
    output logic                            o_last,
    output logic                            o_overflow
);

    localparam int VB = ils_pkg::VALUE_BITS;
    localparam int CW = ils_pkg::CNT_W;
    localparam int UW = ils_pkg::CUR_W;
    localparam int AW = ils_pkg::ADDR_W;

    logic [VB-1:0] mem_lo [ils_pkg::MAX_ENTRIES];
    logic [VB-1:0] mem_hi [ils_pkg::MAX_ENTRIES];

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_wp;
    logic [CW-1:0] r_k;
    logic          r_ovf;
    logic          r_have;
    logic          r_strobe;

    logic [VB-1:0] r_rd_lo;
    logic [VB-1:0] r_rd_hi;
    logic [VB-1:0] r_hi;
    logic          r_end;
    logic [UW-1:0] r_cursor;
    logic [VB-1:0] r_pend_lo;
    logic [VB-1:0] r_pend_hi;
    logic [VB-1:0] r_out_lo;
    logic [VB-1:0] r_out_hi;
    logic          r_out_valid;
    logic          r_out_last;
    logic          r_out_ovf;

    logic in_ok;
    logic has_room;
    logic low_gt_cur;
    logic high_ge_cur;
    logic cur_le_hi;

    assign in_ok       = (i_lo <= i_hi);
    assign has_room    = (r_count < CW'(ils_pkg::MAX_ENTRIES));
    assign low_gt_cur  = ({1'b0, r_rd_lo} > r_cursor);
    assign high_ge_cur = ({1'b0, r_rd_hi} >= r_cursor);
    assign cur_le_hi   = (r_cursor <= {1'b0, r_hi});

    assign o_sts.k_lt_cnt  = (r_k < r_count);
    assign o_sts.skip_cond = !high_ge_cur;
    assign o_sts.walk_cond = (r_rd_lo <= r_hi) && cur_le_hi;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && in_ok && has_room) begin
            mem_lo[r_count[AW-1:0]] <= i_lo;
            mem_hi[r_count[AW-1:0]] <= i_hi;
        end
        r_rd_lo <= mem_lo[r_k[AW-1:0]];
        r_rd_hi <= mem_hi[r_k[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_wp     <= '0;
            r_k      <= '0;
            r_ovf    <= 1'b0;
            r_have   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cmd.load && in_ok) begin
                if (has_room) begin
                    r_count <= r_count + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.start_sub) begin
                r_k    <= r_wp;
                r_have <= 1'b0;
            end
            if (i_cmd.skip_adv) begin
                r_k <= r_k + CW'(1);
            end
            if (i_cmd.skip_done) begin
                r_wp <= r_k;
            end
            if (i_cmd.walk_step) begin
                r_k <= r_k + CW'(1);
                if (low_gt_cur) begin
                    r_have   <= 1'b1;
                    r_strobe <= r_have;
                end
            end
            if (i_cmd.tail && cur_le_hi) begin
                r_have   <= 1'b1;
                r_strobe <= r_have;
            end
            if (i_cmd.fin) begin
                r_strobe <= 1'b1;
                if (r_end) begin
                    r_count <= '0;
                    r_wp    <= '0;
                    r_k     <= '0;
                    r_ovf   <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_sub) begin
            r_hi     <= i_hi;
            r_end    <= i_last_of_list;
            r_cursor <= {1'b0, i_lo};
        end
        if (i_cmd.walk_step) begin
            if (low_gt_cur) begin
                if (r_have) begin
                    r_out_lo    <= r_pend_lo;
                    r_out_hi    <= r_pend_hi;
                    r_out_valid <= 1'b1;
                    r_out_last  <= 1'b0;
                    r_out_ovf   <= r_ovf;
                end
                r_pend_lo <= r_cursor[VB-1:0];
                r_pend_hi <= r_rd_lo - VB'(1);
            end
            if (high_ge_cur) begin
                r_cursor <= {1'b0, r_rd_hi} + UW'(1);
            end
        end
        if (i_cmd.tail && cur_le_hi) begin
            if (r_have) begin
                r_out_lo    <= r_pend_lo;
                r_out_hi    <= r_pend_hi;
                r_out_valid <= 1'b1;
                r_out_last  <= 1'b0;
                r_out_ovf   <= r_ovf;
            end
            r_pend_lo <= r_cursor[VB-1:0];
            r_pend_hi <= r_hi;
        end
        if (i_cmd.fin) begin
            r_out_lo    <= r_have ? r_pend_lo : '0;
            r_out_hi    <= r_have ? r_pend_hi : '0;
            r_out_valid <= r_have;
            r_out_last  <= 1'b1;
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_piece_lo    = r_out_lo;
    assign o_piece_hi    = r_out_hi;
    assign o_piece_valid = r_out_valid;
    assign o_last        = r_out_last;
    assign o_overflow    = r_out_ovf;

    `ILS_ASSERT_NOW(a_wp_le_count, 1'b1, r_wp <= r_count, "walk pointer beyond entry count")
    `ILS_ASSERT_NOW(a_k_le_count, 1'b1, r_k <= r_count, "walk index beyond entry count")
    `ILS_ASSERT_NEXT(a_fin_emits_last, i_cmd.fin, r_strobe && r_out_last, "final word missing")
    `ILS_ASSERT_NOW(a_empty_is_last, r_strobe && !r_out_valid, r_out_last,
                    "empty word not marked last")

endmodule

// File: hw/rtl/interval_list_subtractor_unit.sv
// Load word (func 0): accepted in idle, no result; busy stays low.
// Subtract word (func 1): store entries are skipped or walked through read and check states (one
// registered store read port), then the tail and final states run before the next accept.
// Each result strobes the cycle after its decision; the final word in the first idle cycle.
// Results are single-cycle strobes; the receiver cannot stall, so none is held back.
// Synchronous reset clears entry count, walk pointer, overflow flag and state, not the store.
module interval_list_subtractor_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_func,
    input  logic [ils_pkg::VALUE_BITS-1:0]  i_lo,
    input  logic [ils_pkg::VALUE_BITS-1:0]  i_hi,
    input  logic                            i_last_of_list,
    output logic                            o_strobe,
    output logic [ils_pkg::VALUE_BITS-1:0]  o_piece_lo,
    output logic [ils_pkg::VALUE_BITS-1:0]  o_piece_hi,
    output logic                            o_piece_valid,
    output logic                            o_last,
    output logic                            o_overflow
);

    ils_pkg::t_dp_cmd cmd;
    ils_pkg::t_dp_sts sts;

    ils_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_func),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    ils_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_lo           (i_lo),
        .i_hi           (i_hi),
        .i_last_of_list (i_last_of_list),
        .o_sts          (sts),
        .o_strobe       (o_strobe),
        .o_piece_lo     (o_piece_lo),
        .o_piece_hi     (o_piece_hi),
        .o_piece_valid  (o_piece_valid),
        .o_last         (o_last),
        .o_overflow     (o_overflow)
    );

endmodule

// File: sim/tb_interval_list_subtractor_unit.sv
`timescale 1ns / 1ps

module tb_interval_list_subtractor_unit;

    localparam int VB = ils_pkg::VALUE_BITS;
    localparam int MAXE = ils_pkg::MAX_ENTRIES;
    localparam logic [VB:0] TOP = {1'b0, {VB{1'b1}}};

    typedef struct {
        logic          fn;
        logic [VB-1:0] lo;
        logic [VB-1:0] hi;
        logic          eol;
    } t_word;

    typedef struct {
        logic [VB-1:0] lo;
        logic [VB-1:0] hi;
        logic          valid;
        logic          last;
        logic          ovf;
    } t_piece;

    class piece_scoreboard;
        logic [VB-1:0] sub_lo [MAXE];
        logic [VB-1:0] sub_hi [MAXE];
        int            held;
        int            walk;
        logic          ovf;
        t_piece        expected_pieces [$];
        int            errors;

        function new();
            held = 0;
            walk = 0;
            ovf = 1'b0;
            errors = 0;
        endfunction

        function int pending();
            return expected_pieces.size();
        endfunction

        function void push_piece(logic [VB-1:0] lo, logic [VB-1:0] hi, logic v, logic l);
            t_piece p;
            p.lo = lo;
            p.hi = hi;
            p.valid = v;
            p.last = l;
            p.ovf = ovf;
            expected_pieces.insert(expected_pieces.size(), p);
        endfunction

        function void subtract_minuend(logic [VB-1:0] lo, logic [VB-1:0] hi, logic eol);
            logic [VB:0]   cursor;
            logic [VB-1:0] pend_lo;
            logic [VB-1:0] pend_hi;
            logic          have;
            int            k;
            cursor = {1'b0, lo};
            have = 1'b0;
            pend_lo = '0;
            pend_hi = '0;
            k = walk;
            while (k < held && {1'b0, sub_hi[k]} < cursor) k++;
            walk = k;
            while (k < held && sub_lo[k] <= hi && cursor <= {1'b0, hi}) begin
                if ({1'b0, sub_lo[k]} > cursor) begin
                    if (have) push_piece(pend_lo, pend_hi, 1'b1, 1'b0);
                    pend_lo = cursor[VB-1:0];
                    pend_hi = sub_lo[k] - 1'b1;
                    have = 1'b1;
                end
                if ({1'b0, sub_hi[k]} >= cursor) cursor = {1'b0, sub_hi[k]} + 1'b1;
                k++;
            end
            if (cursor <= {1'b0, hi}) begin
                if (have) push_piece(pend_lo, pend_hi, 1'b1, 1'b0);
                pend_lo = cursor[VB-1:0];
                pend_hi = hi;
                have = 1'b1;
            end
            if (have) push_piece(pend_lo, pend_hi, 1'b1, 1'b1);
            else push_piece('0, '0, 1'b0, 1'b1);
            if (eol) begin
                held = 0;
                walk = 0;
                ovf = 1'b0;
            end
        endfunction

        function void note_word(logic fn, logic [VB-1:0] lo, logic [VB-1:0] hi, logic eol);
            if (fn) begin
                subtract_minuend(lo, hi, eol);
            end else if (lo <= hi) begin
                if (held < MAXE) begin
                    sub_lo[held] = lo;
                    sub_hi[held] = hi;
                    held++;
                end else begin
                    ovf = 1'b1;
                end
            end
        endfunction

        function void check_piece(logic [VB-1:0] lo, logic [VB-1:0] hi, logic v, logic l,
                                  logic o);
            t_piece e;
            if (expected_pieces.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected piece lo=%h hi=%h valid=%b last=%b ovf=%b",
                             lo, hi, v, l, o);
                return;
            end
            e = expected_pieces.pop_front();
            if (e.lo !== lo || e.hi !== hi || e.valid !== v || e.last !== l || e.ovf !== o)
            begin
                errors++;
                if (errors <= 10) begin
                    $display("piece mismatch: exp lo=%h hi=%h valid=%b last=%b ovf=%b",
                             e.lo, e.hi, e.valid, e.last, e.ovf);
                    $display("                got lo=%h hi=%h valid=%b last=%b ovf=%b",
                             lo, hi, v, l, o);
                end
            end
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    logic          i_func;
    logic [VB-1:0] i_lo;
    logic [VB-1:0] i_hi;
    logic          i_last_of_list;
    logic          o_strobe;
    logic [VB-1:0] o_piece_lo;
    logic [VB-1:0] o_piece_hi;
    logic          o_piece_valid;
    logic          o_last;
    logic          o_overflow;

    piece_scoreboard sb;
    t_word           job_words [$];
    int              counted;

    interval_list_subtractor_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_lo           (i_lo),
        .i_hi           (i_hi),
        .i_last_of_list (i_last_of_list),
        .o_strobe       (o_strobe),
        .o_piece_lo     (o_piece_lo),
        .o_piece_hi     (o_piece_hi),
        .o_piece_valid  (o_piece_valid),
        .o_last         (o_last),
        .o_overflow     (o_overflow)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) sb.note_word(i_func, i_lo, i_hi, i_last_of_list);
            if (o_strobe) sb.check_piece(o_piece_lo, o_piece_hi, o_piece_valid, o_last,
                                         o_overflow);
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_word(logic fn, logic [VB-1:0] lo, logic [VB-1:0] hi,
                                     logic eol);
        t_word w;
        w.fn = fn;
        w.lo = lo;
        w.hi = hi;
        w.eol = eol;
        job_words.insert(job_words.size(), w);
    endfunction

    function automatic void add_ascending(int n, logic fn, logic [VB:0] base,
                                          int unsigned s);
        logic [VB:0] cur;
        logic [VB:0] lo;
        logic [VB:0] hi;
        cur = base;
        for (int i = 0; i < n; i++) begin
            lo = cur + (VB+1)'($urandom_range(0, 3)) * (VB+1)'(s);
            if (lo > TOP) break;
            hi = lo + (VB+1)'($urandom_range(0, 3 * s));
            if (hi > TOP) hi = TOP;
            add_word(fn, lo[VB-1:0], hi[VB-1:0], 1'b0);
            if (hi == TOP) break;
            cur = hi + 1'b1;
        end
    endfunction

    task automatic send_word(t_word w);
        start <= 1'b1;
        i_func <= w.fn;
        i_lo <= w.lo;
        i_hi <= w.hi;
        i_last_of_list <= w.eol;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic pause_sender(int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic run_job(bit burst, bit drain);
        for (int i = 0; i < job_words.size(); i++) begin
            send_word(job_words[i]);
            counted++;
            if (i == job_words.size() - 1 && drain) drain_results();
            else pause_sender(burst ? 0 : gap_len());
        end
        job_words.delete();
    endtask

    task automatic build_random_job(bit force_ovf);
        int unsigned s;
        logic [VB:0] base;
        int          kind;
        int          a;
        int          b;
        t_word       t;
        kind = $urandom_range(0, 99);
        case ($urandom_range(0, 4))
            0: s = 1;
            1: s = 16;
            2: s = 4096;
            3: s = 1 << 26;
            default: s = 1 << 29;
        endcase
        case ($urandom_range(0, 2))
            0: base = '0;
            1: base = {1'b0, VB'($urandom)};
            default: base = TOP - (VB+1)'($urandom_range(0, 200));
        endcase
        if (force_ovf || kind < 10) begin
            add_ascending($urandom_range(MAXE + 1, MAXE + 4), 1'b0, '0, 1);
            add_ascending($urandom_range(1, 6), 1'b1, '0, 4);
        end else if (kind < 25) begin
            repeat ($urandom_range(3, 10)) begin
                if ($urandom_range(0, 1))
                    add_word(1'($urandom_range(0, 1)), VB'($urandom), VB'($urandom),
                             $urandom_range(0, 9) == 0);
                else
                    add_word(1'($urandom_range(0, 1)), VB'($urandom_range(0, 40)),
                             VB'($urandom_range(0, 40)), $urandom_range(0, 9) == 0);
            end
        end else begin
            add_ascending($urandom_range(0, 8), 1'b0, base, s);
            add_ascending($urandom_range(1, 6), 1'b1, base, s);
            if (kind < 35 && job_words.size() > 2) begin
                a = $urandom_range(0, job_words.size() - 1);
                b = $urandom_range(0, job_words.size() - 1);
                t = job_words[a];
                job_words[a] = job_words[b];
                job_words[b] = t;
            end
        end
        if (job_words.size() == 0 || job_words[job_words.size() - 1].fn != 1'b1)
            add_word(1'b1, VB'($urandom), VB'($urandom), 1'b0);
        job_words[job_words.size() - 1].eol = 1'b1;
    endtask

    initial begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        sb = new();
        counted = 0;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_func <= 1'b0;
        i_lo <= '0;
        i_hi <= '0;
        i_last_of_list <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_word(1'b1, '0, '1, 1'b0);
        add_word(1'b0, '0, '0, 1'b1);
        add_word(1'b0, 5, 9, 1'b0);
        add_word(1'b0, 7, 3, 1'b0);
        add_word(1'b0, 20, 29, 1'b0);
        add_word(1'b0, '1, '1, 1'b0);
        add_word(1'b1, 0, 3, 1'b0);
        add_word(1'b1, 4, 30, 1'b0);
        add_word(1'b1, 40, 10, 1'b0);
        add_word(1'b1, 25, 27, 1'b0);
        add_word(1'b1, VB'(32'hFFFF_FFF0), '1, 1'b1);
        add_word(1'b0, 100, 200, 1'b0);
        add_word(1'b1, 100, 200, 1'b0);
        add_word(1'b1, 150, 300, 1'b1);
        add_word(1'b0, '0, '1, 1'b0);
        add_word(1'b1, '0, '1, 1'b1);
        run_job(1'b0, 1'b1);

        build_random_job(1'b1);
        run_job(1'b0, 1'b1);
        while (counted < 110) begin
            build_random_job(1'b0);
            run_job($urandom_range(0, 3) == 0, $urandom_range(0, 4) == 0);
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
